/* src/sac_pkg.sv */
// Shared types and constants for the set-associative cache tag block.
// Used by the way compare unit, the top level, its checker and the testbench.
`default_nettype none

package sac_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int WAYS_DEF      = 4;
  localparam int SETS_DEF      = 64;
  localparam int ADDR_BITS_DEF = 48;

  // Fixed field widths.
  localparam int STAMP_W   = 32;
  localparam int SET_RAW_W = 7;
  localparam int WAY_OUT_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REPL_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_SETS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_LINE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd3;

  // Replacement modes.
  localparam logic REPL_LRU    = 1'b0;
  localparam logic REPL_DIRECT = 1'b1;

  // Access kinds.
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_WRITE
  } sac_state_t;

  // Result of comparing one way against the lookup tag and the current victim.
  typedef struct packed {
    logic match;
    logic older;
  } way_cmp_t;

endpackage

`default_nettype wire

/* src/sac_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/sac_way_unit.sv */
// Shared compare unit: checks one way for a tag hit and against the victim's stamp.
// Depends on sac_pkg.
`default_nettype none

module sac_way_unit #(
  parameter int ADDR_BITS = sac_pkg::ADDR_BITS_DEF
) (
  input  wire logic                        way_valid,
  input  wire logic [ADDR_BITS-1:0]        way_tag,
  input  wire logic [sac_pkg::STAMP_W-1:0] way_stamp,
  input  wire logic [ADDR_BITS-1:0]        lookup_tag,
  input  wire logic [sac_pkg::STAMP_W-1:0] victim_stamp,
  output sac_pkg::way_cmp_t                cmp
);

  import sac_pkg::*;

  // Less-or-equal lets a later way take a tie, so the highest way wins.
  always_comb begin
    cmp.match = way_valid && (way_tag == lookup_tag);
    cmp.older = (way_stamp <= victim_stamp);
  end

endmodule

`default_nettype wire

/* src/set_assoc_cache_lru_tags.sv */
// Top level of the set-associative cache tag and state block.
// Depends on sac_pkg, sac_ram and sac_way_unit.
// The block keeps tag, valid, dirty and LRU stamp for every line of a
// set-associative, write-back, write-allocate cache in one RAM row per set.
// After reset it runs a clearing pass, one set per cycle, during which
// in_ready stays low; configuration writes are taken at any time.
// An access then passes through its states in order: it is accepted, the set
// index is reduced and the row read issued (the reduction subtracts SETS
// again and again while the masked index is not below SETS), one
// shared compare unit walks the ways in use (stopping at the first hit,
// otherwise visiting all N ways), and the updated row is written back.
// The result item sits in an output register, so a new access is accepted
// while it waits; the row write waits only if the previous result has still
// not been taken.
`default_nettype none

module set_assoc_cache_lru_tags #(
  parameter int WAYS      = sac_pkg::WAYS_DEF,
  parameter int SETS      = sac_pkg::SETS_DEF,
  parameter int ADDR_BITS = sac_pkg::ADDR_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration write channel.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sac_pkg::CFG_W-1:0]     cfg_data,
  // Access channel.
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          kind,
  input  wire logic [ADDR_BITS-1:0]          address,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               hit,
  output logic                               writeback,
  output logic [sac_pkg::WAY_OUT_W-1:0]      way_used
);

  import sac_pkg::*;

  // Each way entry is {valid, dirty, stamp, tag}; a row holds all ways of a set.
  localparam int ENTRY_W = ADDR_BITS + STAMP_W + 2;
  localparam int ROW_W   = WAYS * ENTRY_W;
  localparam int SET_AW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W   = $clog2(WAYS + 1);
  localparam int SV_W    = (SET_AW + 1 > SET_RAW_W) ? SET_AW + 1 : SET_RAW_W;
  localparam int DIRTY_B = ADDR_BITS + STAMP_W;
  localparam int VALID_B = ADDR_BITS + STAMP_W + 1;

  // Configuration registers.
  logic       repl_mode;
  logic [2:0] log2_sets;
  logic [3:0] log2_line;
  logic [2:0] ways_cfg;

  // Sequencer state and per-access registers.
  sac_state_t            state, state_next;
  logic [SET_AW-1:0]     clear_idx;
  logic [SV_W-1:0]       set_val;
  logic [ADDR_BITS-1:0]  tag_r;
  logic                  kind_r;
  logic [STAMP_W-1:0]    access_count;
  logic [WAY_W-1:0]      way;
  logic [WAY_W-1:0]      victim;
  logic [WAY_W-1:0]      sel_way;
  logic                  res_hit;

  // Control decoded by the sequencer.
  logic in_accept;
  logic out_free;
  logic ram_rd_en;
  logic ram_wr_en;
  logic clear_last;
  logic reduce_done;
  logic scan_last;
  logic scan_hit;
  logic write_go;

  logic [CNT_W-1:0]      nways;
  logic [SET_RAW_W-1:0]  set_mask;
  logic [SET_RAW_W-1:0]  set_raw;
  logic [ADDR_BITS-1:0]  addr_shift;
  logic [ADDR_BITS-1:0]  line_tag;
  logic [SET_AW-1:0]     set_idx;

  logic [ROW_W-1:0]      rd_row;
  logic [ROW_W-1:0]      new_row;
  logic [ROW_W-1:0]      wr_row;
  logic [SET_AW-1:0]     wr_addr;
  logic [ENTRY_W-1:0]    cur_entry;
  logic [ENTRY_W-1:0]    vic_entry;
  logic [ENTRY_W-1:0]    sel_entry;
  logic                  dirty_new;
  way_cmp_t              cmp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      repl_mode <= REPL_LRU;
      log2_sets <= 3'd6;
      log2_line <= 4'd6;
      ways_cfg  <= 3'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REPL_MODE:   repl_mode <= cfg_data[0];
        REG_LOG2_SETS:   log2_sets <= cfg_data[2:0];
        REG_LOG2_LINE:   log2_line <= cfg_data;
        REG_WAYS_IN_USE: ways_cfg  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // A ways setting of zero searches one way; anything past WAYS searches all.
  always_comb begin
    if (ways_cfg == 3'd0) begin
      nways = CNT_W'(1);
    end else if (32'(ways_cfg) > WAYS) begin
      nways = CNT_W'(WAYS);
    end else begin
      nways = CNT_W'(ways_cfg);
    end
  end

  // Address split: the line address keeps the bits above the offset, and the
  // raw set index is the masked bits just above it.
  assign line_tag   = address & ({ADDR_BITS{1'b1}} << log2_line);
  assign addr_shift = address >> log2_line;
  assign set_mask   = SET_RAW_W'((8'd1 << log2_sets) - 8'd1);
  assign set_raw    = addr_shift[SET_RAW_W-1:0] & set_mask;
  assign set_idx    = set_val[SET_AW-1:0];

  // Way selection from the row that the RAM holds on its read port.
  assign cur_entry = rd_row[way * ENTRY_W +: ENTRY_W];
  assign vic_entry = rd_row[victim * ENTRY_W +: ENTRY_W];
  assign sel_entry = rd_row[sel_way * ENTRY_W +: ENTRY_W];

  sac_way_unit #(
    .ADDR_BITS (ADDR_BITS)
  ) u_way_unit (
    .way_valid    (cur_entry[VALID_B]),
    .way_tag      (cur_entry[ADDR_BITS-1:0]),
    .way_stamp    (cur_entry[ADDR_BITS +: STAMP_W]),
    .lookup_tag   (tag_r),
    .victim_stamp (vic_entry[ADDR_BITS +: STAMP_W]),
    .cmp          (cmp)
  );

  // The touched line always ends valid with the new stamp. A hit keeps its
  // dirty bit and a write sets it; a fill is dirty only for a write.
  assign dirty_new = (res_hit && sel_entry[DIRTY_B]) || (kind_r == KIND_WRITE);

  always_comb begin
    new_row = rd_row;
    new_row[sel_way * ENTRY_W +: ENTRY_W] = {1'b1, dirty_new, access_count, tag_r};
  end

  assign wr_row  = (state == ST_CLEAR) ? '0 : new_row;
  assign wr_addr = (state == ST_CLEAR) ? clear_idx : set_idx;

  sac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (ram_rd_en),
    .rd_addr (set_idx),
    .rd_data (rd_row)
  );

  // Sequencer.
  assign out_free    = !out_valid || out_ready;
  assign clear_last  = (clear_idx == SET_AW'(SETS - 1));
  assign reduce_done = (set_val < SV_W'(SETS));
  assign scan_last   = (CNT_W'(way) == (nways - CNT_W'(1)));
  assign scan_hit    = cmp.match;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_rd_en  = 1'b0;
    ram_wr_en  = 1'b0;
    write_go   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_wr_en = 1'b1;
        if (clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (reduce_done) begin
          ram_rd_en  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          ram_wr_en  = 1'b1;
          write_go   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign in_accept = in_ready && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx    <= '0;
      access_count <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clear_idx <= clear_idx + SET_AW'(1);
      end
      if (in_accept) begin
        access_count <= access_count + STAMP_W'(1);
      end
    end
  end

  // Per-access datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r  <= kind;
      tag_r   <= line_tag;
      set_val <= SV_W'(set_raw);
    end
    if (state == ST_REDUCE) begin
      if (!reduce_done) begin
        set_val <= set_val - SV_W'(SETS);
      end else begin
        way    <= '0;
        victim <= '0;
      end
    end
    if (state == ST_SCAN) begin
      if (scan_hit) begin
        res_hit <= 1'b1;
        sel_way <= way;
      end else begin
        res_hit <= 1'b0;
        if (repl_mode == REPL_LRU && cmp.older) begin
          victim  <= way;
          sel_way <= way;
        end else begin
          sel_way <= victim;
        end
        way <= way + WAY_W'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (write_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (write_go) begin
      hit       <= res_hit;
      writeback <= !res_hit && sel_entry[VALID_B] && sel_entry[DIRTY_B];
      way_used  <= WAY_OUT_W'(sel_way);
    end
  end

endmodule

`default_nettype wire

/* src/sac_checker.sv */
// Port-level checker for the cache tag block, with its bind to the top level.
// Depends on sac_pkg.
`default_nettype none

module sac_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          hit,
  input wire logic                          writeback,
  input wire logic [sac_pkg::WAY_OUT_W-1:0] way_used
);

  import sac_pkg::*;

  // The clearing pass keeps the access channel closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("access accepted during the clearing pass");

  // A write-back only ever comes with a miss.
  a_wb_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && writeback |-> !hit)
    else $error("write-back reported on a hit");

  // An accepted item keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while the first is still at work");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(writeback)
      && $stable(way_used))
    else $error("stalled result changed or dropped");

endmodule

bind set_assoc_cache_lru_tags sac_checker u_sac_checker (.*);

`default_nettype wire

/* tb/tb_set_assoc_cache_lru_tags.sv */
`timescale 1ns / 1ps
// Self-checking testbench for set_assoc_cache_lru_tags, the cache tag and LRU state block.
// Depends on sac_pkg for field widths, register indexes, access kinds and replacement modes.
// A built-in cache model predicts hit, write-back and way for every accepted access.

module tb_set_assoc_cache_lru_tags;
  import sac_pkg::*;

  localparam int NWAYS = WAYS_DEF;
  localparam int NSETS = SETS_DEF;
  localparam int AW    = ADDR_BITS_DEF;

  // Worst legal gap between handshakes is the receiver hold-off below, so the
  // watchdog limit sits well above it.
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  // Longest access is a miss that walks four ways plus an extra index reduction
  // step; settling after a drain covers that with margin.
  localparam int SETTLE_CYCLES  = 16;
  localparam int POOL_SIZE      = 12;

  typedef struct packed {
    logic          kind;
    logic [AW-1:0] addr;
  } access_t;

  typedef struct packed {
    logic                 hit;
    logic                 writeback;
    logic [WAY_OUT_W-1:0] way;
  } lookup_result_t;

  // Clock, reset and every block input start at a known value.
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 kind      = KIND_READ;
  logic [AW-1:0]        address   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_ready;
  logic                 in_ready;
  logic                 out_valid;
  logic                 hit;
  logic                 writeback;
  logic [WAY_OUT_W-1:0] way_used;

  always #2 clk = ~clk;

  set_assoc_cache_lru_tags i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .address   (address),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .writeback (writeback),
    .way_used  (way_used)
  );

  // Accesses waiting to be offered, and the lookup results predicted for
  // accesses the block has already taken, oldest first.
  access_t        access_q[$];
  lookup_result_t lookup_results_q[$];
  access_t        next_access;
  lookup_result_t want;

  // Shadow copy of the configuration, updated when a register write is taken.
  logic       cur_mode      = REPL_LRU;
  logic [2:0] cur_log2_sets = 3'd6;
  logic [3:0] cur_log2_line = 4'd6;
  logic [2:0] cur_ways      = 3'd4;

  // Shadow copy of the cache state. Tags are only compared where valid is set.
  logic [AW-1:0] line_tag   [NSETS][NWAYS];
  bit            line_valid [NSETS][NWAYS];
  bit            line_dirty [NSETS][NWAYS];
  bit [31:0]     line_stamp [NSETS][NWAYS];
  bit [31:0]     access_count = '0;

  int  errors        = 0;
  int  accepted_cnt  = 0;
  int  results_seen  = 0;
  int  quiet_cycles  = 0;
  int  hold_left     = 0;
  bit  hold_done     = 1'b0;
  bit  in_fired      = 1'b0;

  // Predicts one access and updates the shadow cache the way the block should.
  // The lookup walks the ways in use from way 0, so when a line sits in more
  // than one way the lowest one hits. On a miss in LRU mode the way with the
  // smallest stamp is replaced, the highest way winning a tie.
  function automatic lookup_result_t lookup_cache(input logic k, input logic [AW-1:0] a);
    logic [63:0]    off_mask;
    logic [63:0]    set_mask;
    logic [63:0]    line_addr;
    logic [63:0]    set_raw;
    int             set_i;
    int             n;
    int             w;
    int             victim;
    lookup_result_t r;
    off_mask  = (64'd1 << cur_log2_line) - 64'd1;
    line_addr = {{(64-AW){1'b0}}, a} & ~off_mask;
    set_mask  = (64'd1 << cur_log2_sets) - 64'd1;
    set_raw   = ({{(64-AW){1'b0}}, a} >> cur_log2_line) & set_mask;
    // An index mask wider than the set count wraps around the sets.
    set_i     = int'(set_raw % NSETS);
    // Zero ways behaves as one, and more than the built-in ways as all of them.
    n = int'(cur_ways);
    if (n < 1) n = 1;
    if (n > NWAYS) n = NWAYS;
    access_count = access_count + 32'd1;
    r = '0;
    for (w = 0; w < n; w++) begin
      if (line_valid[set_i][w] && line_tag[set_i][w] == line_addr[AW-1:0]) begin
        line_stamp[set_i][w] = access_count;
        if (k == KIND_WRITE) line_dirty[set_i][w] = 1'b1;
        r.hit = 1'b1;
        r.way = WAY_OUT_W'(w);
        return r;
      end
    end
    victim = 0;
    if (cur_mode == REPL_LRU) begin
      for (w = 1; w < n; w++) begin
        if (line_stamp[set_i][w] <= line_stamp[set_i][victim]) victim = w;
      end
    end
    r.writeback = line_valid[set_i][victim] && line_dirty[set_i][victim];
    r.way       = WAY_OUT_W'(victim);
    line_tag[set_i][victim]   = line_addr[AW-1:0];
    line_valid[set_i][victim] = 1'b1;
    line_dirty[set_i][victim] = (k == KIND_WRITE);
    line_stamp[set_i][victim] = access_count;
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // Monitor: everything is sampled at the rising edge. Results are checked
  // before a newly taken access is predicted, so the order of the two never
  // depends on the scheduler.
  always @(posedge clk) begin
    in_fired = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (lookup_results_q.size() == 0) begin
          $display("%0t: result item with nothing expected, hit %0d writeback %0d way %0d",
                   $time, hit, writeback, way_used);
          errors++;
        end else begin
          want = lookup_results_q.pop_front();
          check_field("hit", want.hit, hit);
          check_field("writeback", want.writeback, writeback);
          check_field("way_used", want.way, way_used);
        end
      end
      if (in_valid && in_ready) begin
        in_fired = 1'b1;
        accepted_cnt++;
        lookup_results_q.push_back(lookup_cache(kind, address));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REPL_MODE:   cur_mode      = cfg_data[0];
          REG_LOG2_SETS:   cur_log2_sets = cfg_data[2:0];
          REG_LOG2_LINE:   cur_log2_line = cfg_data[3:0];
          REG_WAYS_IN_USE: cur_ways      = cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  // Watchdog: a run in which no channel moves an item for too long has hung.
  // The clearing pass after reset is far shorter than the limit.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Driver: holds an offered access until it is taken, otherwise offers the
  // next queued one or idles about one cycle in five. Idling stops for a
  // stretch in the middle of the run.
  always @(negedge clk) begin
    if (in_valid && !in_fired) begin
      // Item still waiting for the block: keep valid and payload as they are.
    end else if (access_q.size() != 0 &&
                 ((accepted_cnt >= 700 && accepted_cnt < 1000) ||
                  $urandom_range(0, 99) >= 20)) begin
      next_access = access_q.pop_front();
      in_valid <= 1'b1;
      kind     <= next_access.kind;
      address  <= next_access.addr;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: idles about one cycle in five, never idles through a stretch,
  // and once late in the run refuses results for a long hold-off so that the
  // output register stays full and the block has to stop taking accesses.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 1300) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (results_seen >= 700 && results_seen < 1000) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 20);
    end
  end

  task automatic push_access(input logic k, input logic [AW-1:0] a);
    access_t item;
    item.kind = k;
    item.addr = a;
    access_q.push_back(item);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Raw register values; bits above a register's width are written on purpose
  // and must be ignored by the block.
  task automatic set_regs(input logic [3:0] mode, input logic [3:0] sets,
                          input logic [3:0] line, input logic [3:0] ways);
    write_reg(REG_REPL_MODE, mode);
    write_reg(REG_LOG2_SETS, sets);
    write_reg(REG_LOG2_LINE, line);
    write_reg(REG_WAYS_IN_USE, ways);
  endtask

  // Waits until every queued access has been taken and every result has come
  // back, then lets the block settle before the configuration may change.
  task automatic wait_drained();
    while (access_q.size() != 0 || in_valid || lookup_results_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random accesses for the current configuration. Most of them reuse a small
  // pool of lines, most of which are forced into two sets, so that hits,
  // evictions and dirty write-backs all happen often; the offset bits are
  // fresh each time. The rest are fully random addresses.
  task automatic queue_random(input int count);
    logic [63:0] pool [POOL_SIZE];
    logic [63:0] off_mask;
    logic [63:0] set_field;
    logic [63:0] a;
    int          i;
    off_mask  = (64'd1 << cur_log2_line) - 64'd1;
    set_field = ((64'd1 << cur_log2_sets) - 64'd1) << cur_log2_line;
    for (i = 0; i < POOL_SIZE; i++) begin
      pool[i] = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) begin
        pool[i] = (pool[i] & ~set_field) | (64'($urandom_range(0, 1)) << cur_log2_line);
      end
    end
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        a = (pool[$urandom_range(0, POOL_SIZE - 1)] & ~off_mask) |
            ({$urandom, $urandom} & off_mask);
      end else begin
        a = {$urandom, $urandom};
      end
      push_access(1'($urandom_range(0, 1)), a[AW-1:0]);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset configuration: LRU, 64 sets, 64-byte lines, four ways. Lines k<<12
    // all land in set 0. The first miss goes to the highest way, a fifth line
    // evicts the dirty least recently used one, and the all-zero and all-one
    // addresses are both touched.
    push_access(KIND_READ,  48'h0);
    push_access(KIND_WRITE, 48'h3F);
    push_access(KIND_READ,  {AW{1'b1}});
    push_access(KIND_WRITE, {{(AW-6){1'b1}}, 6'd0});
    push_access(KIND_READ,  48'h1000);
    push_access(KIND_READ,  48'h2000);
    push_access(KIND_WRITE, 48'h3000);
    push_access(KIND_READ,  48'h4000);
    push_access(KIND_READ,  48'h0);
    push_access(KIND_WRITE, 48'h1000);
    wait_drained();

    // Direct mode with a single way: the line already held in a higher way is
    // not searched, so it is filled a second time into way 0.
    set_regs(4'h9, 4'h6, 4'h6, 4'h1);
    push_access(KIND_READ, 48'h4000);
    wait_drained();

    // All ways searched again (seven acts as four): both copies match and the
    // lower way must hit. Random traffic follows in this and later settings.
    set_regs(4'hE, 4'h6, 4'h6, 4'hF);
    push_access(KIND_READ,  48'h4000);
    push_access(KIND_WRITE, 48'h4005);
    queue_random(200);
    wait_drained();

    // A single set with the smallest real line size and two ways.
    set_regs(4'h0, 4'h0, 4'h3, 4'h2);
    queue_random(200);
    wait_drained();

    // Index mask wider than the set count, largest real line size, zero ways.
    set_regs(4'h1, 4'hF, 4'hC, 4'h0);
    queue_random(200);
    wait_drained();

    // No offset bits at all, direct mode over three ways.
    set_regs(4'h1, 4'h6, 4'h0, 4'h3);
    queue_random(200);
    wait_drained();

    // Offset width past the usual range and a way count above the maximum.
    set_regs(4'h0, 4'h4, 4'hF, 4'h5);
    queue_random(200);
    wait_drained();

    // Back to the reset-like setting for the long run with the hold-off.
    set_regs(4'h0, 4'hE, 4'h6, 4'hC);
    queue_random(600);
    wait_drained();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
